/* rtl/core/psl_pkg.sv */
// Shared types, codes and constants of the paced byte link.
package psl_pkg;

  localparam int unsigned RX_DEPTH_DEF = 256;
  localparam int unsigned TX_DEPTH_DEF = 1024;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned RX_LVL_W  = 8;
  localparam int unsigned TX_LVL_W  = 10;
  localparam int unsigned ETX_CNT_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [BYTE_W-1:0]    BYTE_STX = 8'h02;
  localparam logic [BYTE_W-1:0]    BYTE_ETX = 8'h03;
  localparam logic [ETX_CNT_W-1:0] ETX_MAX  = 5'd31;
  localparam logic [ETX_CNT_W-1:0] ETX_LIMIT_RST = 5'd16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETX_LIMIT   = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_RECV  = 3'd2,
    OP_ATTN  = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_TXFULL  = 3'd1,
    ST_RXFULL  = 3'd2,
    ST_RXEMPTY = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HUNT = 2'd1,
    MODE_MSG  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              port_busy;
  } item_t;

  // result word minus the bytes that come out of the ring memories
  typedef struct packed {
    status_e             status;
    logic                send_valid;
    logic                send_from_ring;
    logic [BYTE_W-1:0]   send_fill;
    logic                read_valid;
    mode_e               link_state;
    logic [RX_LVL_W-1:0] rx_level;
    logic [TX_LVL_W-1:0] tx_level;
  } res_meta_t;

endpackage

/* rtl/core/psl_ifs.sv */
// Word channels of the paced byte link: input, result and configuration.
interface psl_in_if;
  logic                        valid;
  logic                        ready;
  logic [psl_pkg::OP_W-1:0]    opcode;
  logic [psl_pkg::BYTE_W-1:0]  data_byte;
  logic                        byte_present;
  logic                        port_busy;

  modport source (output valid, opcode, data_byte, byte_present, port_busy, input ready);
  modport sink   (input valid, opcode, data_byte, byte_present, port_busy, output ready);
endinterface

interface psl_out_if;
  logic                          valid;
  logic                          ready;
  logic [psl_pkg::STATUS_W-1:0]  status;
  logic                          send_valid;
  logic [psl_pkg::BYTE_W-1:0]    send_byte;
  logic                          read_valid;
  logic [psl_pkg::BYTE_W-1:0]    read_byte;
  logic [1:0]                    link_state;
  logic [psl_pkg::RX_LVL_W-1:0]  rx_level;
  logic [psl_pkg::TX_LVL_W-1:0]  tx_level;

  modport source (output valid, status, send_valid, send_byte, read_valid, read_byte,
                  link_state, rx_level, tx_level, input ready);
  modport sink   (input valid, status, send_valid, send_byte, read_valid, read_byte,
                  link_state, rx_level, tx_level, output ready);
endinterface

interface psl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [psl_pkg::CFG_IDX_W-1:0]  index;
  logic [psl_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/psl_ram.sv */
// Ring storage: one write port, one read port with registered read data.
module psl_ram #(
  parameter int unsigned DEPTH = psl_pkg::RX_DEPTH_DEF,
  parameter int unsigned WIDTH = psl_pkg::BYTE_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/paced_spi_byte_link.sv */
// Paced byte link: receive ring, transmit ring and message monitor behind word channels.
//
// Every input word produces exactly one result word. A word is captured in an input
// register, handled in one pass (monitor, ring pointers, link state) once the result
// register is free, and its result lands in the output register at the end of that pass;
// one word is taken per cycle while the result side keeps up. Ring bytes come from
// synchronous memories (one write and one read port per ring); their read data is
// registered beside the result word.
// A stalled result holds the pass and, through it, the input register. Each ring keeps
// one slot free and holds DEPTH-1 bytes; ring contents need no clearing after reset.
// Configuration writes are taken in any cycle (ready is always high) and should be
// issued only while no word is in flight.
module paced_spi_byte_link #(
  parameter int unsigned RX_DEPTH = psl_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = psl_pkg::TX_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psl_in_if.sink     in_i,
  psl_out_if.source  res_o,
  psl_cfg_if.sink    cfg_i
);

  import psl_pkg::*;

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  // configuration
  logic                 link_enable_q;
  logic [ETX_CNT_W-1:0] etx_limit_q;

  // link state
  logic [RX_AW-1:0]     rx_wptr_q, rx_wptr_d, rx_rptr_q, rx_rptr_d;
  logic [TX_AW-1:0]     tx_wptr_q, tx_wptr_d, tx_rptr_q, tx_rptr_d;
  mode_e                mode_q, mode_d;
  logic [ETX_CNT_W-1:0] etx_seen_q, etx_seen_d;

  // pipeline
  logic      s1_valid_q;
  item_t     s1_q;
  logic      s2_valid_q;
  res_meta_t s2_q, s2_d;
  logic      s1_adv, s1_fire;

  // ring ports
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  //--------------------------------------------------------------------------
  // Configuration port
  //--------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_enable_q <= 1'b0;
      etx_limit_q   <= ETX_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LINK_ENABLE: link_enable_q <= cfg_i.data[0];
        CFG_ETX_LIMIT:   etx_limit_q   <= cfg_i.data[ETX_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Pipeline control: advance the pass when the result register is free
  //--------------------------------------------------------------------------
  assign s1_adv     = !s2_valid_q || res_o.ready;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.opcode       <= in_i.opcode;
      s1_q.data_byte    <= in_i.data_byte;
      s1_q.byte_present <= in_i.byte_present;
      s1_q.port_busy    <= in_i.port_busy;
    end
    if (s1_fire) begin
      s2_q <= s2_d;
    end
  end

  //--------------------------------------------------------------------------
  // Single pass over one word
  //--------------------------------------------------------------------------
  logic [RX_AW-1:0]     rx_wptr_inc, rx_rptr_inc;
  logic [TX_AW-1:0]     tx_wptr_inc, tx_rptr_inc;
  logic                 rx_full, rx_empty, tx_full, tx_empty;
  mode_e                base_mode, mon_mode;
  logic [ETX_CNT_W-1:0] mon_etx, etx_bump;
  logic [RX_AW:0]       rx_lvl;
  logic [TX_AW:0]       tx_lvl;
  op_e                  op;

  assign op = op_e'(s1_q.opcode);

  assign rx_wptr_inc = (rx_wptr_q == RX_LAST) ? '0 : rx_wptr_q + 1'b1;
  assign rx_rptr_inc = (rx_rptr_q == RX_LAST) ? '0 : rx_rptr_q + 1'b1;
  assign tx_wptr_inc = (tx_wptr_q == TX_LAST) ? '0 : tx_wptr_q + 1'b1;
  assign tx_rptr_inc = (tx_rptr_q == TX_LAST) ? '0 : tx_rptr_q + 1'b1;

  assign rx_full  = (rx_wptr_inc == rx_rptr_q);
  assign rx_empty = (rx_wptr_q == rx_rptr_q);
  assign tx_full  = (tx_wptr_inc == tx_rptr_q);
  assign tx_empty = (tx_wptr_q == tx_rptr_q);

  // attention wakes an idle link before the drained byte is watched
  assign base_mode = (op == OP_ATTN && mode_q == MODE_IDLE) ? MODE_HUNT : mode_q;
  assign etx_bump  = (etx_seen_q < ETX_MAX) ? etx_seen_q + 1'b1 : etx_seen_q;

  // protocol monitor: STX opens a message, too many ETX bytes close it
  always_comb begin
    mon_mode = base_mode;
    mon_etx  = etx_seen_q;
    if (s1_q.data_byte == BYTE_STX) begin
      mon_mode = MODE_MSG;
      mon_etx  = '0;
    end else if (s1_q.data_byte == BYTE_ETX) begin
      mon_etx = etx_bump;
      if (etx_bump > etx_limit_q) begin
        mon_mode = MODE_IDLE;
      end
    end
  end

  always_comb begin
    logic take, do_send;
    take       = 1'b0;
    do_send    = 1'b0;
    rx_wptr_d  = rx_wptr_q;
    rx_rptr_d  = rx_rptr_q;
    tx_wptr_d  = tx_wptr_q;
    tx_rptr_d  = tx_rptr_q;
    mode_d     = mode_q;
    etx_seen_d = etx_seen_q;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    s2_d.status         = ST_OK;
    s2_d.send_valid     = 1'b0;
    s2_d.send_from_ring = 1'b0;
    s2_d.send_fill      = '0;
    s2_d.read_valid     = 1'b0;

    case (op)
      OP_PUSH: begin
        if (tx_full) begin
          s2_d.status = ST_TXFULL;
        end else begin
          tx_we     = s1_fire;
          tx_wptr_d = tx_wptr_inc;
        end
      end
      OP_POP: begin
        if (rx_empty) begin
          s2_d.status = ST_RXEMPTY;
        end else begin
          s2_d.read_valid = 1'b1;
          rx_re           = s1_fire;
          rx_rptr_d       = rx_rptr_inc;
        end
      end
      OP_RECV: begin
        if (!link_enable_q) begin
          s2_d.status = ST_IGNORED;
        end else begin
          take = 1'b1;
        end
      end
      OP_ATTN: begin
        if (!link_enable_q || s1_q.port_busy) begin
          s2_d.status = ST_IGNORED;
        end else begin
          mode_d = base_mode;
          take   = s1_q.byte_present;
          // send if data waits or the link is live after the drained byte
          do_send = !tx_empty ||
                    ((s1_q.byte_present ? mon_mode : base_mode) != MODE_IDLE);
        end
      end
      OP_START: begin
        do_send = 1'b1;
      end
      default: begin
        s2_d.status = ST_IGNORED;
      end
    endcase

    if (take) begin
      mode_d     = mon_mode;
      etx_seen_d = mon_etx;
      if (rx_full) begin
        s2_d.status = ST_RXFULL;
      end else begin
        rx_we     = s1_fire;
        rx_wptr_d = rx_wptr_inc;
      end
    end

    if (do_send) begin
      s2_d.send_valid = 1'b1;
      if (tx_empty) begin
        s2_d.send_fill = BYTE_ETX;
      end else begin
        s2_d.send_from_ring = 1'b1;
        tx_re               = s1_fire;
        tx_rptr_d           = tx_rptr_inc;
      end
    end

    // levels after the word, from the updated pointers
    rx_lvl = (rx_wptr_d >= rx_rptr_d) ?
             {1'b0, rx_wptr_d} - {1'b0, rx_rptr_d} :
             {1'b0, rx_wptr_d} + (RX_AW + 1)'(RX_DEPTH) - {1'b0, rx_rptr_d};
    tx_lvl = (tx_wptr_d >= tx_rptr_d) ?
             {1'b0, tx_wptr_d} - {1'b0, tx_rptr_d} :
             {1'b0, tx_wptr_d} + (TX_AW + 1)'(TX_DEPTH) - {1'b0, tx_rptr_d};

    s2_d.link_state = mode_d;
    s2_d.rx_level   = RX_LVL_W'(rx_lvl);
    s2_d.tx_level   = TX_LVL_W'(tx_lvl);
  end

  // commit the link state when the pass moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wptr_q  <= '0;
      rx_rptr_q  <= '0;
      tx_wptr_q  <= '0;
      tx_rptr_q  <= '0;
      mode_q     <= MODE_IDLE;
      etx_seen_q <= '0;
    end else if (s1_fire) begin
      rx_wptr_q  <= rx_wptr_d;
      rx_rptr_q  <= rx_rptr_d;
      tx_wptr_q  <= tx_wptr_d;
      tx_rptr_q  <= tx_rptr_d;
      mode_q     <= mode_d;
      etx_seen_q <= etx_seen_d;
    end
  end

  //--------------------------------------------------------------------------
  // Rings
  //--------------------------------------------------------------------------
  psl_ram #(
    .DEPTH (RX_DEPTH),
    .WIDTH (BYTE_W)
  ) u_rx_ring (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wptr_q),
    .wdata_i (s1_q.data_byte),
    .re_i    (rx_re),
    .raddr_i (rx_rptr_q),
    .rdata_o (rx_rdata)
  );

  psl_ram #(
    .DEPTH (TX_DEPTH),
    .WIDTH (BYTE_W)
  ) u_tx_ring (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wptr_q),
    .wdata_i (s1_q.data_byte),
    .re_i    (tx_re),
    .raddr_i (tx_rptr_q),
    .rdata_o (tx_rdata)
  );

  //--------------------------------------------------------------------------
  // Result word: merge the registered ring bytes in
  //--------------------------------------------------------------------------
  assign res_o.valid      = s2_valid_q;
  assign res_o.status     = s2_q.status;
  assign res_o.send_valid = s2_q.send_valid;
  assign res_o.send_byte  = s2_q.send_from_ring ? tx_rdata : s2_q.send_fill;
  assign res_o.read_valid = s2_q.read_valid;
  assign res_o.read_byte  = s2_q.read_valid ? rx_rdata : '0;
  assign res_o.link_state = s2_q.link_state;
  assign res_o.rx_level   = s2_q.rx_level;
  assign res_o.tx_level   = s2_q.tx_level;

endmodule

/* rtl/core/psl_chk.sv */
// Port-level checks of the paced byte link, bound to its top level.
module psl_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [psl_pkg::STATUS_W-1:0]   status_i,
  input logic                           send_valid_i,
  input logic [psl_pkg::BYTE_W-1:0]     send_byte_i,
  input logic                           read_valid_i,
  input logic [psl_pkg::BYTE_W-1:0]     read_byte_i,
  input logic [1:0]                     link_state_i
);

  import psl_pkg::*;

  // a stalled word holds still
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(send_byte_i) && $stable(read_byte_i) && $stable(link_state_i))
    else $error("result word changed while stalled");

  // a popped byte only comes with an ok status
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_valid_i |-> status_i == ST_OK && !send_valid_i)
    else $error("popped byte with a non-ok status or a send");

  // no send byte without a send
  a_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !send_valid_i |-> send_byte_i == '0)
    else $error("send byte without send_valid");

  // ignored words and rejected pushes and pops never send or read
  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_IGNORED || status_i == ST_TXFULL ||
      status_i == ST_RXEMPTY) |-> !send_valid_i && !read_valid_i && read_byte_i == '0)
    else $error("ignored or rejected word moved a byte");

endmodule

bind paced_spi_byte_link psl_chk u_psl_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .status_i     (res_o.status),
  .send_valid_i (res_o.send_valid),
  .send_byte_i  (res_o.send_byte),
  .read_valid_i (res_o.read_valid),
  .read_byte_i  (res_o.read_byte),
  .link_state_i (res_o.link_state)
);

/* tb/sv/paced_spi_byte_link_tb.sv */
// Self-checking testbench of the paced byte link: directed table, then random traffic.
module paced_spi_byte_link_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;

  // Ring sizes of the instance under test (package defaults).
  localparam int unsigned RXD = RX_DEPTH_DEF;
  localparam int unsigned TXD = TX_DEPTH_DEF;

  // Opcodes past the defined set: the block must ignore them.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [ETX_CNT_W-1:0] ETX_LIMIT_TOP = 5'd30;

  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 4000;

  // One result word as the output channel carries it.
  typedef struct packed {
    status_e             status;
    logic                send_valid;
    logic [BYTE_W-1:0]   send_byte;
    logic                read_valid;
    logic [BYTE_W-1:0]   read_byte;
    mode_e               link_state;
    logic [RX_LVL_W-1:0] rx_level;
    logic [TX_LVL_W-1:0] tx_level;
  } link_result_t;

  // One line of the directed table: a register write or a word.
  typedef struct {
    bit                   cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    item_t                word;
    bit                   pinned;
    link_result_t         pinned_result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  psl_in_if  in_if ();
  psl_out_if res_if ();
  psl_cfg_if cfg_if ();

  paced_spi_byte_link uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Shadow of the link: rings, pointers, monitor state and registers.
  // Ring entries are only read after they were written.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]    rx_ring [RXD];
  logic [BYTE_W-1:0]    tx_ring [TXD];
  int unsigned          rx_wr = 0;
  int unsigned          rx_rd = 0;
  int unsigned          tx_wr = 0;
  int unsigned          tx_rd = 0;
  mode_e                link_mode = MODE_IDLE;
  logic [ETX_CNT_W-1:0] etx_count = '0;
  logic                 link_on = 1'b0;
  logic [ETX_CNT_W-1:0] etx_limit = ETX_LIMIT_RST;

  link_result_t link_results_q[$];
  stim_row_t    directed_rows[$];

  // Run bookkeeping for the summary.
  int unsigned words_sent      = 0;
  int unsigned busy_words      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned tx_rejects      = 0;
  int unsigned rx_rejects      = 0;
  int unsigned etx_saturations = 0;
  int unsigned message_ends    = 0;
  int unsigned segments_run    = 0;

  // Pacing knobs shared by the stimulus and the result sink.
  bit in_calm      = 1'b0;
  bit out_calm     = 1'b0;
  bit hold_request = 1'b0;

  function automatic int unsigned ring_fill(int unsigned wr, int unsigned rd,
                                            int unsigned depth);
    return (wr + depth - rd) % depth;
  endfunction

  function automatic int unsigned ring_next(int unsigned p, int unsigned depth);
    return (p + 1) % depth;
  endfunction

  // Protocol monitor: STX opens a message, a run of ETX past the limit closes it.
  function automatic void watch_byte(logic [BYTE_W-1:0] b);
    if (b == BYTE_STX) begin
      link_mode = MODE_MSG;
      etx_count = '0;
    end else if (b == BYTE_ETX) begin
      if (etx_count < ETX_MAX) etx_count = etx_count + 1'b1;
      else etx_saturations++;
      if (etx_count > etx_limit) begin
        if (link_mode != MODE_IDLE) message_ends++;
        link_mode = MODE_IDLE;
      end
    end
  endfunction

  // Watch, then store one received byte; a full ring drops it.
  function automatic status_e store_rx_byte(logic [BYTE_W-1:0] b);
    watch_byte(b);
    if (ring_next(rx_wr, RXD) == rx_rd) begin
      rx_rejects++;
      return ST_RXFULL;
    end
    rx_ring[rx_wr] = b;
    rx_wr = ring_next(rx_wr, RXD);
    return ST_OK;
  endfunction

  // Ring head, or ETX filler when the transmit ring is empty.
  function automatic logic [BYTE_W-1:0] pull_tx_byte();
    logic [BYTE_W-1:0] b;
    if (ring_fill(tx_wr, tx_rd, TXD) == 0) return BYTE_ETX;
    b = tx_ring[tx_rd];
    tx_rd = ring_next(tx_rd, TXD);
    return b;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    if (idx == CFG_LINK_ENABLE) link_on = d[0];
    else if (idx == CFG_ETX_LIMIT) etx_limit = d[ETX_CNT_W-1:0];
  endfunction

  // Advance the shadow by one accepted word and return the result it causes.
  function automatic link_result_t apply_word(item_t w);
    link_result_t r;
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_PUSH: begin
        if (ring_next(tx_wr, TXD) == tx_rd) begin
          r.status = ST_TXFULL;
          tx_rejects++;
        end else begin
          tx_ring[tx_wr] = w.data_byte;
          tx_wr = ring_next(tx_wr, TXD);
        end
      end
      OP_POP: begin
        if (ring_fill(rx_wr, rx_rd, RXD) == 0) begin
          r.status = ST_RXEMPTY;
        end else begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_ring[rx_rd];
          rx_rd = ring_next(rx_rd, RXD);
        end
      end
      OP_RECV: begin
        if (!link_on) r.status = ST_IGNORED;
        else r.status = store_rx_byte(w.data_byte);
      end
      OP_ATTN: begin
        if (!link_on || w.port_busy) begin
          r.status = ST_IGNORED;
        end else begin
          if (link_mode == MODE_IDLE) link_mode = MODE_HUNT;
          if (w.byte_present) r.status = store_rx_byte(w.data_byte);
          if (ring_fill(tx_wr, tx_rd, TXD) != 0 || link_mode != MODE_IDLE) begin
            r.send_valid = 1'b1;
            r.send_byte  = pull_tx_byte();
          end
        end
      end
      OP_START: begin
        r.send_valid = 1'b1;
        r.send_byte  = pull_tx_byte();
      end
      default: r.status = ST_IGNORED;
    endcase
    r.link_state = link_mode;
    r.rx_level   = RX_LVL_W'(ring_fill(rx_wr, rx_rd, RXD));
    r.tx_level   = TX_LVL_W'(ring_fill(tx_wr, tx_rd, TXD));
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones; none in a calm stretch.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic link_result_t pinned(status_e st, logic sv, logic [BYTE_W-1:0] sb,
                                          mode_e md, int unsigned rxl, int unsigned txl);
    link_result_t r;
    r = '0;
    r.status     = st;
    r.send_valid = sv;
    r.send_byte  = sb;
    r.link_state = md;
    r.rx_level   = RX_LVL_W'(rxl);
    r.tx_level   = TX_LVL_W'(txl);
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Count cycles with no handshake on any channel; a stuck link ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] no word moved for %0d cycles, %0d results still due",
             $time, QUIET_LIMIT, link_results_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold  = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      // Take a pending hold request and count it down here.
      if (hold_request) begin
        hold = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        stall = pick_gap(out_calm);
      end
    end
  end

  // Compare every accepted result word with the oldest one due.
  always @(posedge clk_i) begin : result_check
    link_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (link_results_q.size() == 0) begin
        note_mismatch("unexpected result word, status", res_if.status, 0);
      end else begin
        want = link_results_q.pop_front();
        results_checked++;
        if (res_if.status != want.status)
          note_mismatch("status", res_if.status, want.status);
        if (res_if.send_valid != want.send_valid)
          note_mismatch("send_valid", res_if.send_valid, want.send_valid);
        if (res_if.send_byte != want.send_byte)
          note_mismatch("send_byte", res_if.send_byte, want.send_byte);
        if (res_if.read_valid != want.read_valid)
          note_mismatch("read_valid", res_if.read_valid, want.read_valid);
        if (res_if.read_byte != want.read_byte)
          note_mismatch("read_byte", res_if.read_byte, want.read_byte);
        if (res_if.link_state != want.link_state)
          note_mismatch("link_state", res_if.link_state, want.link_state);
        if (res_if.rx_level != want.rx_level)
          note_mismatch("rx_level", res_if.rx_level, want.rx_level);
        if (res_if.tx_level != want.tx_level)
          note_mismatch("tx_level", res_if.tx_level, want.tx_level);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one word after a random gap and hold it until the block takes it.
  // On acceptance, advance the shadow and queue the result that is due.
  task automatic offer_word(item_t w, bit is_pinned, link_result_t want);
    int unsigned  gap;
    link_result_t got;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= w.opcode;
    in_if.data_byte    <= w.data_byte;
    in_if.byte_present <= w.byte_present;
    in_if.port_busy    <= w.port_busy;
    do @(posedge clk_i); while (!in_if.ready);
    got = apply_word(w);
    words_sent++;
    if (got.status != ST_IGNORED) busy_words++;
    link_results_q.push_back(is_pinned ? want : got);
  endtask

  task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d, logic p, logic b);
    item_t w;
    w.opcode       = op;
    w.data_byte    = d;
    w.byte_present = p;
    w.port_busy    = b;
    offer_word(w, 1'b0, '0);
  endtask

  // Drop valid, let every due result drain and the pipe settle, then write.
  task automatic settle_and_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (link_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_cfg(idx, d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  task automatic row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    stim_row_t row;
    row = '{default: '0};
    row.cfg_write = 1'b1;
    row.cfg_index = idx;
    row.cfg_data  = d;
    directed_rows.push_back(row);
  endtask

  task automatic row_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d, logic p, logic b,
                          bit is_pinned, link_result_t want);
    stim_row_t row;
    row = '{default: '0};
    row.word.opcode       = op;
    row.word.data_byte    = d;
    row.word.byte_present = p;
    row.word.port_busy    = b;
    row.pinned            = is_pinned;
    row.pinned_result     = want;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    // Out of reset the link is closed: receive and attention are ignored,
    // while push, pop and start send still work.
    row_word(OP_RECV, 8'hFF, 1'b0, 1'b0, 1,
             pinned(ST_IGNORED, 1'b0, 8'h00, MODE_IDLE, 0, 0));
    row_word(OP_ATTN, BYTE_STX, 1'b1, 1'b0, 1,
             pinned(ST_IGNORED, 1'b0, 8'h00, MODE_IDLE, 0, 0));
    row_word(OP_POP, 8'h00, 1'b0, 1'b0, 1,
             pinned(ST_RXEMPTY, 1'b0, 8'h00, MODE_IDLE, 0, 0));
    // Start send on an empty ring sends filler.
    row_word(OP_START, 8'h00, 1'b0, 1'b0, 1,
             pinned(ST_OK, 1'b1, BYTE_ETX, MODE_IDLE, 0, 0));
    row_word(OP_SPARE_7, 8'hFF, 1'b1, 1'b1, 1,
             pinned(ST_IGNORED, 1'b0, 8'h00, MODE_IDLE, 0, 0));
    row_word(OP_PUSH, 8'h00, 1'b0, 1'b0, 1,
             pinned(ST_OK, 1'b0, 8'h00, MODE_IDLE, 0, 1));
    row_word(OP_PUSH, 8'hFF, 1'b1, 1'b1, 1,
             pinned(ST_OK, 1'b0, 8'h00, MODE_IDLE, 0, 2));
    // Open the link with the tightest ETX limit.
    row_cfg(CFG_LINK_ENABLE, 8'h01);
    row_cfg(CFG_ETX_LIMIT, 8'h00);
    // A busy port swallows the attention event.
    row_word(OP_ATTN, BYTE_STX, 1'b1, 1'b1, 1,
             pinned(ST_IGNORED, 1'b0, 8'h00, MODE_IDLE, 0, 2));
    row_word(OP_ATTN, 8'h55, 1'b0, 1'b0, 0, '0);
    row_word(OP_RECV, BYTE_STX, 1'b0, 1'b0, 0, '0);
    row_word(OP_RECV, BYTE_ETX, 1'b0, 1'b0, 0, '0);
    row_word(OP_ATTN, BYTE_ETX, 1'b1, 1'b0, 0, '0);
    row_word(OP_ATTN, 8'hAA, 1'b0, 1'b0, 0, '0);
    row_word(OP_POP, 8'h00, 1'b0, 1'b0, 0, '0);
    row_word(OP_POP, 8'h00, 1'b0, 1'b0, 0, '0);
    row_word(OP_POP, 8'h00, 1'b0, 1'b0, 0, '0);
    row_word(OP_POP, 8'h00, 1'b0, 1'b0, 0, '0);
    // Limit of 31 through a byte with the upper bits set: messages never end.
    row_cfg(CFG_ETX_LIMIT, 8'hFF);
    row_word(OP_RECV, BYTE_STX, 1'b1, 1'b1, 0, '0);
    row_word(OP_RECV, BYTE_ETX, 1'b0, 1'b0, 0, '0);
    row_word(OP_RECV, BYTE_ETX, 1'b0, 1'b0, 0, '0);
    row_word(OP_SPARE_5, 8'h5A, 1'b0, 1'b1, 0, '0);
    row_word(OP_SPARE_6, 8'hA5, 1'b1, 1'b0, 0, '0);
    row_cfg(CFG_ETX_LIMIT, {3'b000, ETX_LIMIT_TOP});
    // Writes to indexes with no register behind them change nothing.
    row_cfg(CFG_SPARE_2, 8'h55);
    row_cfg(CFG_SPARE_3, 8'hAA);
    row_word(OP_RECV, 8'h80, 1'b0, 1'b0, 0, '0);
    row_word(OP_RECV, 8'h7F, 1'b0, 1'b0, 0, '0);
    row_word(OP_POP, 8'h00, 1'b0, 1'b0, 0, '0);
    // Close the link again, upper data bits set.
    row_cfg(CFG_LINK_ENABLE, 8'hFE);
    row_word(OP_ATTN, 8'h01, 1'b1, 1'b0, 0, '0);
    row_word(OP_RECV, BYTE_STX, 1'b0, 1'b0, 0, '0);
    row_word(OP_START, 8'h00, 1'b0, 1'b0, 0, '0);
    row_word(OP_PUSH, 8'hAA, 1'b0, 1'b0, 0, '0);
    row_cfg(CFG_LINK_ENABLE, 8'h01);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // Hand one byte in from the port: a plain receive or a byte drained by attention.
  task automatic recv_byte(logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 2) == 0) send_word(OP_ATTN, b, 1'b1, 1'b0);
    else send_word(OP_RECV, b, 1'b0, 1'b0);
  endtask

  // Host traffic between port bytes; pops keep the receive ring from creeping up.
  task automatic side_traffic();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) send_word(OP_POP, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (r < 60) send_word(OP_PUSH, 8'($urandom), 1'($urandom), 1'($urandom));
    else if (r < 70) send_word(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Wake the link, frame a payload with STX, close it with a run of ETX.
  // Some messages are broken: one in five has no STX, one in five an ETX run too short to end it.
  task automatic run_message();
    int unsigned n;
    int unsigned run;
    send_word(OP_ATTN, 8'($urandom), 1'b0, 1'b0);
    if ($urandom_range(0, 4) != 0) recv_byte(BYTE_STX);
    n = $urandom_range(1, 12);
    repeat (n) begin
      recv_byte(8'($urandom));
      side_traffic();
    end
    // A limit of 31 cannot end the message; run past saturation instead.
    run = (etx_limit == ETX_MAX) ? ETX_MAX + 3 : etx_limit + 1;
    if ($urandom_range(0, 4) == 0) run = $urandom_range(0, etx_limit);
    repeat (run) begin
      recv_byte(BYTE_ETX);
      side_traffic();
    end
    send_word(OP_ATTN, 8'($urandom), 1'b0, 1'b0);
  endtask

  // Weighted mix of all operations.
  task automatic run_traffic(int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 25) send_word(OP_PUSH, 8'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 50) send_word(OP_POP, 8'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 65) send_word(OP_RECV, 8'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 85)
        send_word(OP_ATTN, 8'($urandom), 1'($urandom), ($urandom_range(0, 9) == 0));
      else if (r < 95) send_word(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
      else send_word(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), 8'($urandom),
                     1'($urandom), 1'($urandom));
    end
  endtask

  // Every field fully random, spare opcodes included.
  task automatic run_noise();
    repeat (30)
      send_word(3'($urandom_range(0, OP_SPARE_7)), 8'($urandom), 1'($urandom),
                1'($urandom));
  endtask

  // Fill the transmit ring to the brim, push past it, then send a few bytes out;
  // later traffic drains the rest.
  task automatic fill_tx();
    while (ring_fill(tx_wr, tx_rd, TXD) < TXD - 1)
      send_word(OP_PUSH, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat (3) send_word(OP_PUSH, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat (4) begin
      if ($urandom_range(0, 1) == 0) send_word(OP_START, 8'($urandom), 1'b0, 1'b0);
      else send_word(OP_ATTN, 8'($urandom), 1'b0, 1'b0);
    end
    send_word(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Fill the receive ring, overflow it both ways, then pop it dry and once more.
  task automatic fill_rx();
    while (ring_fill(rx_wr, rx_rd, RXD) < RXD - 1) recv_byte(8'($urandom));
    repeat (2) send_word(OP_RECV, 8'($urandom), 1'b0, 1'b0);
    send_word(OP_ATTN, 8'($urandom), 1'b1, 1'b0);
    while (ring_fill(rx_wr, rx_rd, RXD) > 0)
      send_word(OP_POP, 8'($urandom), 1'($urandom), 1'($urandom));
    send_word(OP_POP, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // New settings for a segment: extremes of the limit early on, small ones after
  // so that messages stay short; upper data bits are random throughout.
  task automatic pick_settings(int unsigned seg);
    logic [CFG_DAT_W-1:0] d;
    d = 8'($urandom);
    d[0] = (seg <= 4) || ($urandom_range(0, 7) != 0);
    settle_and_write(CFG_LINK_ENABLE, d);
    d = 8'($urandom);
    case (seg)
      2:       d[ETX_CNT_W-1:0] = ETX_MAX;
      4:       d[ETX_CNT_W-1:0] = '0;
      6:       d[ETX_CNT_W-1:0] = ETX_LIMIT_TOP;
      default: d[ETX_CNT_W-1:0] = 5'($urandom_range(0, 8));
    endcase
    settle_and_write(CFG_ETX_LIMIT, d);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned seg;
    // Drive every input to a known value before the first edge.
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_PUSH;
    in_if.data_byte    = '0;
    in_if.byte_present = 1'b0;
    in_if.port_busy    = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_LINK_ENABLE;
    cfg_if.data        = '0;

    // Hold reset, then release it away from the rising edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed table.
    build_directed();
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write)
        settle_and_write(directed_rows[i].cfg_index, directed_rows[i].cfg_data);
      else
        offer_word(directed_rows[i].word, directed_rows[i].pinned,
                   directed_rows[i].pinned_result);
    end

    // Random segments; some run calm on one side or both so that
    // back-to-back stretches appear between the gappy ones.
    seg = 0;
    while (seg < 14 || busy_words < RANDOM_WORDS) begin
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      case (seg)
        3: begin
          settle_and_write(CFG_LINK_ENABLE, 8'h01);
          fill_tx();
        end
        5: begin
          // Hold off the result side for a long stretch while the input keeps
          // offering words back to back, so the block backs up and stalls.
          hold_request = 1'b1;
          in_calm = 1'b1;
          run_traffic(40);
        end
        7: begin
          settle_and_write(CFG_LINK_ENABLE, 8'h01);
          fill_rx();
        end
        default: begin
          if (seg <= 6 || $urandom_range(0, 1) == 0) pick_settings(seg);
          if (seg <= 4) run_message();
          else begin
            case ($urandom_range(0, 3))
              0, 1: run_message();
              2:    run_traffic(40);
              default: run_noise();
            endcase
          end
        end
      endcase
      seg++;
    end
    segments_run = seg;

    // Drop valid, let the last results drain, then let the pipe settle.
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (link_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run: %0d words, %0d taken up by the link, %0d segments, %0d compared.",
             words_sent, busy_words, segments_run, results_checked);
    $display("Seen: %0d tx rejects, %0d rx drops, %0d ETX saturations, %0d message ends.",
             tx_rejects, rx_rejects, etx_saturations, message_ends);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
